@@ src/mfw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared constants, types and register codes of the median filter window.
// ----------------------------------------------------------------------------
package mfw_pkg;

  // Filter geometry and sample format.
  localparam int KSIZE       = 3;
  localparam int MAX_WIDTH   = 2048;
  localparam int SAMPLE_BITS = 16;
  localparam int NCH         = 3;
  localparam int WIN         = KSIZE * KSIZE;
  localparam int PAD         = (KSIZE - 1) / 2;
  localparam int MID         = (WIN - 1) / 2;

  // Counter and port widths.
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int STEP_BITS = $clog2(MAX_WIDTH + PAD);
  localparam int DIM_BITS  = 12;
  localparam int ROW_BITS  = DIM_BITS + 1;
  localparam int SLOT_BITS = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CH_W      = 16;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [NCH-1:0]      pixel_t;
  typedef sample_t [WIN-1:0]      wvec_t;

  // Control that travels alongside the data through the filter pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic fdone;
  } tag_t;

endpackage

@@ src/mfw_pix_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_pix_if
// Input channel: one pixel or flush word per handshake.
// ----------------------------------------------------------------------------
interface mfw_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [mfw_pkg::CH_W-1:0]    channel_0;
  logic [mfw_pkg::CH_W-1:0]    channel_1;
  logic [mfw_pkg::CH_W-1:0]    channel_2;

  modport source (output valid, kind, channel_0, channel_1, channel_2, input ready);
  modport sink (input valid, kind, channel_0, channel_1, channel_2, output ready);
endinterface

@@ src/mfw_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_res_if
// Result channel: one filtered pixel word per handshake.
// ----------------------------------------------------------------------------
interface mfw_res_if;
  logic                        valid;
  logic                        ready;
  logic [mfw_pkg::CH_W-1:0]    median_0;
  logic [mfw_pkg::CH_W-1:0]    median_1;
  logic [mfw_pkg::CH_W-1:0]    median_2;
  logic                        last_of_run;
  logic                        frame_done;

  modport source (output valid, median_0, median_1, median_2, last_of_run, frame_done,
                  input ready);
  modport sink (input valid, median_0, median_1, median_2, last_of_run, frame_done,
                output ready);
endinterface

@@ src/mfw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mfw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the output holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mfw_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_lane
// One channel lane: pipelined odd-even transposition sort, median tap.
// ----------------------------------------------------------------------------
module mfw_lane (
  input  logic             clk,
  input  logic             en,
  input  mfw_pkg::wvec_t   vals,
  output mfw_pkg::sample_t median
);

  mfw_pkg::wvec_t st  [mfw_pkg::WIN];
  mfw_pkg::wvec_t nxt [mfw_pkg::WIN];

  // One compare-exchange layer per stage, alternating pair parity.
  for (genvar s = 0; s < mfw_pkg::WIN; s++) begin : g_stage
    always_comb begin
      mfw_pkg::wvec_t src;
      src = (s == 0) ? vals : st[(s == 0) ? 0 : s - 1];
      nxt[s] = src;
      for (int j = s % 2; j + 1 < mfw_pkg::WIN; j += 2) begin
        if (src[j] > src[j+1]) begin
          nxt[s][j]   = src[j+1];
          nxt[s][j+1] = src[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nxt[s];
      end
    end
  end

  assign median = st[mfw_pkg::WIN-1][mfw_pkg::MID];

endmodule

@@ src/median_filter_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_window
// KSIZE x KSIZE zero-padded median filter over three-channel raster pixels.
// ----------------------------------------------------------------------------
// Pipeline: a result passes the window read, the shift, WIN sort stages and
//   the output register after the word that completes its window is accepted.
// Throughput: one word per cycle inside a row while results are taken; each row
//   end stalls the input for its last steps and the next row's column preloads,
//   and each frame end holds the input while the last row's steps finish, all
//   set by the window sequencer and stretched by result stalls.
// Reset: rst is synchronous; counters, valid bits and the window clear at once,
//   registers return to 640 x 480. The line stores need no clearing pass.
// ----------------------------------------------------------------------------
module median_filter_window (
  input  logic                          clk,
  input  logic                          rst,
  mfw_pix_if.sink                       pixel,
  mfw_res_if.source                     result,
  input  logic                          cfg_write,
  input  logic [mfw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfw_pkg::CFG_W-1:0]     cfg_data
);

  localparam int K  = mfw_pkg::KSIZE;
  localparam int P  = mfw_pkg::PAD;
  localparam int RB = mfw_pkg::ROW_BITS;
  localparam int CB = mfw_pkg::COL_BITS;
  localparam int SB = mfw_pkg::STEP_BITS;
  localparam int LB = mfw_pkg::SLOT_BITS;
  localparam int DB = mfw_pkg::DIM_BITS;
  localparam logic [LB-1:0] TOP_RESET = LB'(K - P);

  // Configuration and frame control state.
  logic [DB-1:0] w_eff, h_eff;
  logic [RB-1:0] in_row, out_row, last_row;
  logic [CB-1:0] in_col, last_col;
  logic [LB-1:0] in_slot, top_slot;
  logic [SB-1:0] step;
  logic          have, frame_wait;

  // Derived limits.
  logic [RB-1:0] h_end;
  logic [CB-1:0] w_last;
  logic [SB-1:0] step_end, w_last_s;
  assign h_end    = RB'(h_eff) + RB'(P) - RB'(1);
  assign w_last   = CB'(w_eff - DB'(1));
  assign w_last_s = SB'(w_eff - DB'(1));
  assign step_end = SB'(w_eff) + SB'(P) - SB'(1);

  // A window step may run once the word that completes it has been taken.
  function automatic logic step_ready(input logic [RB-1:0] row, input logic [SB-1:0] k,
                                      input logic [SB-1:0] wl, input logic [RB-1:0] lr,
                                      input logic [CB-1:0] lc, input logic hv);
    logic [RB-1:0] need_r;
    logic [SB-1:0] kk, need_c;
    need_r = row + RB'(P);
    kk     = (k < SB'(P)) ? SB'(P) : k;
    need_c = (kk > wl) ? wl : kk;
    return hv && ((need_r < lr) || ((need_r == lr) && (need_c <= SB'(lc))));
  endfunction

  // Sequencer: current and following window step.
  logic          fdone_step, elig0, elig1, en, issue, acc, in_live, take, we;
  logic [RB-1:0] row1;
  logic [SB-1:0] step1;
  logic          res_valid;

  always_comb begin
    if (step == step_end) begin
      step1 = '0;
      row1  = out_row + RB'(1);
    end else begin
      step1 = step + SB'(1);
      row1  = out_row;
    end
  end

  assign fdone_step = (out_row == RB'(h_eff) - RB'(1)) && (step == step_end);
  assign elig0 = step_ready(out_row, step, w_last_s, last_row, last_col, have);
  assign elig1 = !fdone_step && step_ready(row1, step1, w_last_s, last_row, last_col, have);
  assign en    = !res_valid || result.ready;
  assign issue = elig0 && en;

  // Input side: no word while a frame drains or an eligible step must wait.
  assign pixel.ready = !frame_wait && (!elig0 || (issue && !elig1));
  assign acc     = pixel.valid && pixel.ready;
  assign in_live = in_row < RB'(h_eff);
  assign take    = acc && !(in_live && (pixel.kind == mfw_pkg::KIND_FLUSH));
  assign we      = acc && in_live && (pixel.kind == mfw_pkg::KIND_PIXEL);

  // Configuration writes and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff      <= DB'(mfw_pkg::WIDTH_RESET);
      h_eff      <= DB'(mfw_pkg::HEIGHT_RESET);
      in_row     <= '0;
      in_col     <= '0;
      in_slot    <= '0;
      out_row    <= '0;
      step       <= '0;
      top_slot   <= TOP_RESET;
      have       <= 1'b0;
      frame_wait <= 1'b0;
      last_row   <= '0;
      last_col   <= '0;
    end else if (cfg_write) begin
      unique case (mfw_pkg::cfg_reg_t'(cfg_index))
        mfw_pkg::REG_WIDTH: begin
          if (cfg_data == '0) w_eff <= DB'(1);
          else if (32'(cfg_data) > mfw_pkg::MAX_WIDTH) w_eff <= DB'(mfw_pkg::MAX_WIDTH);
          else w_eff <= DB'(cfg_data);
        end
        mfw_pkg::REG_HEIGHT: begin
          h_eff <= (cfg_data == '0) ? DB'(1) : DB'(cfg_data);
        end
        default: ;
      endcase
      in_row     <= '0;
      in_col     <= '0;
      in_slot    <= '0;
      out_row    <= '0;
      step       <= '0;
      top_slot   <= TOP_RESET;
      have       <= 1'b0;
      frame_wait <= 1'b0;
    end else begin
      // Output sequencer advance.
      if (issue) begin
        if (fdone_step) begin
          out_row    <= '0;
          step       <= '0;
          top_slot   <= TOP_RESET;
          have       <= 1'b0;
          frame_wait <= 1'b0;
        end else if (step == step_end) begin
          step     <= '0;
          out_row  <= out_row + RB'(1);
          top_slot <= (top_slot == LB'(K - 1)) ? '0 : top_slot + LB'(1);
        end else begin
          step <= step + SB'(1);
        end
      end
      // Input position advance.
      if (take) begin
        last_row <= in_row;
        last_col <= in_col;
        have     <= 1'b1;
        if ((in_row == h_end) && (in_col == w_last)) begin
          in_row     <= '0;
          in_col     <= '0;
          in_slot    <= '0;
          frame_wait <= 1'b1;
        end else if (in_col == w_last) begin
          in_col  <= '0;
          in_row  <= in_row + RB'(1);
          in_slot <= (in_slot == LB'(K - 1)) ? '0 : in_slot + LB'(1);
        end else begin
          in_col <= in_col + CB'(1);
        end
      end
    end
  end

  // Line stores, one per row slot, all read at the step column.
  mfw_pkg::pixel_t wpix;
  mfw_pkg::pixel_t rd [K];
  assign wpix[0] = mfw_pkg::SAMPLE_BITS'(pixel.channel_0);
  assign wpix[1] = mfw_pkg::SAMPLE_BITS'(pixel.channel_1);
  assign wpix[2] = mfw_pkg::SAMPLE_BITS'(pixel.channel_2);

  for (genvar s = 0; s < K; s++) begin : g_line
    mfw_ram #(
      .WIDTH($bits(mfw_pkg::pixel_t)),
      .DEPTH(mfw_pkg::MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (we && (in_slot == LB'(s))),
      .waddr (in_col),
      .wdata (wpix),
      .re    (en),
      .raddr (step[CB-1:0]),
      .rdata (rd[s])
    );
  end

  // Step stage: border masks and flags that go with the read.
  logic          s0_valid, s0_colv, s0_emit, s0_last, s0_fdone;
  logic [K-1:0]  s0_rmask, rmask;
  logic [LB-1:0] s0_top;

  always_comb begin
    for (int dr = 0; dr < K; dr++) begin
      rmask[dr] = ((out_row + RB'(dr)) >= RB'(P)) &&
                  ((out_row + RB'(dr)) < (RB'(h_eff) + RB'(P)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_colv  <= step < SB'(w_eff);
      s0_emit  <= step >= SB'(P);
      s0_last  <= (step < w_last_s) || (step == step_end);
      s0_fdone <= fdone_step;
      s0_rmask <= rmask;
      s0_top   <= top_slot;
    end
  end

  // Window stage: shift the new column in on the right.
  mfw_pkg::wvec_t win      [mfw_pkg::NCH];
  mfw_pkg::wvec_t win_next [mfw_pkg::NCH];
  mfw_pkg::tag_t  s1_tag;

  always_comb begin
    logic [LB:0] sel;
    for (int ch = 0; ch < mfw_pkg::NCH; ch++) begin
      win_next[ch] = win[ch];
    end
    for (int dr = 0; dr < K; dr++) begin
      sel = (LB + 1)'(s0_top) + (LB + 1)'(dr);
      if (sel >= (LB + 1)'(K)) sel = sel - (LB + 1)'(K);
      for (int ch = 0; ch < mfw_pkg::NCH; ch++) begin
        for (int dc = 0; dc < K - 1; dc++) begin
          win_next[ch][dr*K+dc] = win[ch][dr*K+dc+1];
        end
        win_next[ch][dr*K+K-1] = (s0_colv && s0_rmask[dr]) ? rd[LB'(sel)][ch] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      for (int ch = 0; ch < mfw_pkg::NCH; ch++) begin
        win[ch] <= '0;
      end
      s1_tag <= '0;
    end else if (en) begin
      if (s0_valid) begin
        for (int ch = 0; ch < mfw_pkg::NCH; ch++) begin
          win[ch] <= win_next[ch];
        end
      end
      s1_tag <= '{valid: s0_valid && s0_emit, last: s0_last, fdone: s0_fdone};
    end
  end

  // Channel lanes and the tag chain that runs beside them.
  mfw_pkg::sample_t med [mfw_pkg::NCH];
  mfw_pkg::tag_t    tags [mfw_pkg::WIN];

  for (genvar ch = 0; ch < mfw_pkg::NCH; ch++) begin : g_lane
    mfw_lane u_lane (
      .clk    (clk),
      .en     (en),
      .vals   (win[ch]),
      .median (med[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mfw_pkg::WIN; i++) begin
        tags[i] <= '0;
      end
    end else if (en) begin
      tags[0] <= s1_tag;
      for (int i = 1; i < mfw_pkg::WIN; i++) begin
        tags[i] <= tags[i-1];
      end
    end
  end

  // Merge stage: the three lane medians form one result word.
  logic [mfw_pkg::CH_W-1:0] r_med0, r_med1, r_med2;
  logic                     r_last, r_fdone;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= tags[mfw_pkg::WIN-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_med0  <= mfw_pkg::CH_W'(med[0]);
      r_med1  <= mfw_pkg::CH_W'(med[1]);
      r_med2  <= mfw_pkg::CH_W'(med[2]);
      r_last  <= tags[mfw_pkg::WIN-1].last;
      r_fdone <= tags[mfw_pkg::WIN-1].fdone;
    end
  end

  assign result.valid       = res_valid;
  assign result.median_0    = r_med0;
  assign result.median_1    = r_med1;
  assign result.median_2    = r_med2;
  assign result.last_of_run = r_last;
  assign result.frame_done  = r_fdone;

  // Checks on the sequencer.
  a_wait_blocks: assert property (@(posedge clk) disable iff (rst)
    frame_wait |-> !pixel.ready) else $error("word taken while frame drains");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_done) |-> result.last_of_run)
    else $error("frame end without run end");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (issue && fdone_step && !cfg_write) |=> (!have && !frame_wait && (step == '0)))
    else $error("frame end did not restart sequencer");

endmodule
